FILE: src/timed_event_queue_assert.svh
// assertion macros used by the port-level checker file
`ifndef TIMED_EVENT_QUEUE_ASSERT_SVH
`define TIMED_EVENT_QUEUE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TEQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TEQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/teq_pkg.sv
// shared constants for the timed event queue
package teq_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_TIME_BITS   = 32;

	localparam int KIND_W   = 3;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;

	localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
	localparam logic [OP_W-1:0] OP_POP     = 2'd1;
	localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

FILE: src/timed_event_queue.sv
// sorted queue of timed events walked by one shared subtract and compare unit
// full insert, insert into an empty queue, empty pop, empty advance and unknown codes
//   finish straight from idle; other operations walk the entry memory
// one operation at a time, the walk over the entry memory doing one read and at
//   most one write per cycle
// reset clears the entry count and sequencer; entry memory is left as is, no clear pass
module timed_event_queue #(
	parameter int QUEUE_DEPTH = teq_pkg::DEF_QUEUE_DEPTH,
	parameter int TIME_BITS   = teq_pkg::DEF_TIME_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [teq_pkg::OP_W-1:0]      operation,
	input  logic [TIME_BITS-1:0]          time_value,
	input  logic [teq_pkg::KIND_W-1:0]    event_kind,
	output logic                          done,
	output logic [TIME_BITS-1:0]          popped_time,
	output logic [teq_pkg::KIND_W-1:0]    popped_kind,
	output logic [teq_pkg::STATUS_W-1:0]  status,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0] entries_held
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ENT_W = TIME_BITS + teq_pkg::KIND_W;

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_PUT  = 2'd2;

	// entry memory, one entry is {kind, time}
	logic [ENT_W-1:0] mem [QUEUE_DEPTH];

	logic [1:0]                    state_q, state_d;
	logic [teq_pkg::OP_W-1:0]      op_q;
	logic [TIME_BITS-1:0]          val_q;
	logic [teq_pkg::KIND_W-1:0]    kind_q;
	logic [CNT_W-1:0]              count_q, count_d;
	logic [IDX_W-1:0]              idx_q, idx_d;
	logic [ENT_W-1:0]              rd_data_q;

	logic [TIME_BITS-1:0]          res_time_q;
	logic [teq_pkg::KIND_W-1:0]    res_kind_q;
	logic [teq_pkg::STATUS_W-1:0]  res_status_q;
	logic [CNT_W-1:0]              res_count_q;
	logic                          done_q;

	logic                          accept;
	logic [IDX_W-1:0]              rd_addr;
	logic                          wr_en;
	logic [IDX_W-1:0]              wr_addr;
	logic [ENT_W-1:0]              wr_data;
	logic                          fin;
	logic [teq_pkg::STATUS_W-1:0]  fin_status;
	logic                          cap;

	// shared unit: stored time minus operand, borrow says stored < operand
	logic [TIME_BITS-1:0]          rd_time;
	logic [teq_pkg::KIND_W-1:0]    rd_kind;
	logic [TIME_BITS:0]            diff;
	logic                          borrow;
	logic [TIME_BITS-1:0]          clamped;
	logic [CNT_W-1:0]              count_m1;
	logic                          last;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);

	assign rd_time  = rd_data_q[TIME_BITS-1:0];
	assign rd_kind  = rd_data_q[ENT_W-1:TIME_BITS];
	assign diff     = {1'b0, rd_time} - {1'b0, val_q};
	assign borrow   = diff[TIME_BITS];
	assign clamped  = borrow ? '0 : diff[TIME_BITS-1:0];
	assign count_m1 = count_q - CNT_W'(1);
	// entry in the read register is the topmost one held
	assign last     = (CNT_W'(idx_q) == count_m1);

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		count_d    = count_q;
		rd_addr    = idx_q;
		wr_en      = 1'b0;
		wr_addr    = idx_q;
		wr_data    = {kind_q, val_q};
		fin        = 1'b0;
		fin_status = teq_pkg::ST_OK;
		cap        = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (operation)
						teq_pkg::OP_INSERT: begin
							if (count_q == CNT_W'(QUEUE_DEPTH)) begin
								fin        = 1'b1;
								fin_status = teq_pkg::ST_FULL;
							end else if (count_q == '0) begin
								// empty queue takes the event straight at the front
								wr_en   = 1'b1;
								wr_addr = '0;
								wr_data = {event_kind, time_value};
								count_d = CNT_W'(1);
								fin     = 1'b1;
							end else begin
								// walk down from the top entry
								rd_addr = count_m1[IDX_W-1:0];
								idx_d   = count_m1[IDX_W-1:0];
								state_d = S_RUN;
							end
						end
						teq_pkg::OP_POP: begin
							if (count_q == '0) begin
								fin        = 1'b1;
								fin_status = teq_pkg::ST_EMPTY;
							end else begin
								rd_addr = '0;
								idx_d   = '0;
								state_d = S_RUN;
							end
						end
						teq_pkg::OP_ADVANCE: begin
							if (count_q == '0) begin
								fin = 1'b1;
							end else begin
								rd_addr = '0;
								idx_d   = '0;
								state_d = S_RUN;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_RUN: begin
				case (op_q)
					teq_pkg::OP_INSERT: begin
						wr_en   = 1'b1;
						wr_addr = idx_q + IDX_W'(1);
						if (!borrow) begin
							// stored time >= new time: shift it up one slot
							wr_data = rd_data_q;
							if (idx_q == '0) begin
								state_d = S_PUT;
							end else begin
								idx_d   = idx_q - IDX_W'(1);
								rd_addr = idx_q - IDX_W'(1);
							end
						end else begin
							// gap found just above a smaller entry
							count_d = count_q + CNT_W'(1);
							fin     = 1'b1;
						end
					end
					teq_pkg::OP_POP: begin
						if (idx_q == '0) begin
							cap = 1'b1;
						end else begin
							wr_en   = 1'b1;
							wr_addr = idx_q - IDX_W'(1);
							wr_data = rd_data_q;
						end
						if (last) begin
							count_d = count_m1;
							fin     = 1'b1;
						end else begin
							idx_d   = idx_q + IDX_W'(1);
							rd_addr = idx_q + IDX_W'(1);
						end
					end
					teq_pkg::OP_ADVANCE: begin
						wr_en   = 1'b1;
						wr_data = {rd_kind, clamped};
						if (last) begin
							fin = 1'b1;
						end else begin
							idx_d   = idx_q + IDX_W'(1);
							rd_addr = idx_q + IDX_W'(1);
						end
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			S_PUT: begin
				// every entry was >= new time, so it lands at the front
				wr_en   = 1'b1;
				wr_addr = '0;
				count_d = count_q + CNT_W'(1);
				fin     = 1'b1;
			end
			default: begin
				fin = 1'b1;
			end
		endcase
		if (fin) begin
			state_d = S_IDLE;
		end
	end

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// operation latch and result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= operation;
			val_q      <= time_value;
			kind_q     <= event_kind;
			res_time_q <= '0;
			res_kind_q <= '0;
		end
		if (cap) begin
			res_time_q <= rd_time;
			res_kind_q <= rd_kind;
		end
		if (fin) begin
			res_status_q <= fin_status;
			res_count_q  <= count_d;
		end
		idx_q <= idx_d;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= fin;
		end
	end

	// result arrives with the one-cycle done strobe and is held in its registers after it
	assign done         = done_q;
	assign popped_time  = res_time_q;
	assign popped_kind  = res_kind_q;
	assign status       = res_status_q;
	assign entries_held = res_count_q;

endmodule

FILE: src/teq_chk.sv
// port-level checker for the timed event queue, bound into the timed_event_queue module
`include "timed_event_queue_assert.svh"

module teq_chk #(
	parameter int QUEUE_DEPTH = teq_pkg::DEF_QUEUE_DEPTH,
	parameter int TIME_BITS   = teq_pkg::DEF_TIME_BITS
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic                             done,
	input logic [TIME_BITS-1:0]             popped_time,
	input logic [teq_pkg::KIND_W-1:0]       popped_kind,
	input logic [teq_pkg::STATUS_W-1:0]     status,
	input logic [$clog2(QUEUE_DEPTH+1)-1:0] entries_held
);

	`TEQ_ASSERT_IMP(a_done_not_busy, done, !busy, "result strobe while busy")
	`TEQ_ASSERT_NXT(a_accept_moves, start && !busy, done || busy, "accepted op went nowhere")
	`TEQ_ASSERT_IMP(a_busy_ends_done, $fell(busy), done, "busy dropped without a result")
	`TEQ_ASSERT_IMP(a_full_count, done && status == teq_pkg::ST_FULL,
		entries_held == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH), "full drop with room left")
	`TEQ_ASSERT_IMP(a_empty_pop, done && status == teq_pkg::ST_EMPTY,
		entries_held == '0 && popped_time == '0 && popped_kind == '0, "empty pop not clean")

endmodule

bind timed_event_queue teq_chk #(
	.QUEUE_DEPTH(QUEUE_DEPTH),
	.TIME_BITS(TIME_BITS)
) u_teq_chk (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.popped_time(popped_time),
	.popped_kind(popped_kind),
	.status(status),
	.entries_held(entries_held)
);
